@@ src/gsa_pkg.sv @@
// Shared types, constants and helpers for the generational slot allocator.
// No dependencies; the design files refer to it by scoped names, the checker and testbench import it.
`timescale 1ns / 1ps

package gsa_pkg;

  localparam int unsigned PERSISTENT_SLOTS = 1024;
  localparam int unsigned TRANSIENT_SLOTS  = 256;
  localparam int unsigned RESERVED_SLOTS   = 2;
  localparam int unsigned TOTAL_SLOTS      = PERSISTENT_SLOTS + TRANSIENT_SLOTS;

  localparam int unsigned SLOT_W   = 11;
  localparam int unsigned STACK_AW = 10;
  localparam int unsigned GEN_W    = 32;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned PCAP_W   = 11;
  localparam int unsigned TCAP_W   = 9;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 16;

  localparam logic [CFG_AW-1:0] CFG_PCAP   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_TCAP   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_POISON = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_HEAP   = 3'd3;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RETIRE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd5;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_QUERY   = 3'd2,
    OP_RESET   = 3'd3,
    OP_RETIRE  = 3'd4,
    OP_FLUSH   = 3'd5,
    OP_NOP     = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_DISABLED  = 3'd1,
    STS_DEAD      = 3'd2,
    STS_PERS_FULL = 3'd3,
    STS_TRAN_FULL = 3'd4,
    STS_DESC_FAIL = 3'd5,
    STS_STALE     = 3'd6,
    STS_TRAN_REJ  = 3'd7
  } status_e;

  typedef struct packed {
    op_e                op;
    logic               want_t;
    logic               alive;
    logic               desc_ok;
    logic [OWNER_W-1:0] owner;
    logic [SLOT_W-1:0]  hslot;
    logic [GEN_W-1:0]   hgen;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    logic              trans;
    logic              fv;
    logic [SLOT_W-1:0] ff;
    logic [SLOT_W-1:0] fe;
  } res_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [GEN_W-1:0]   gen;
    logic               live;
    logic               trans;
  } slot_t;

  function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 32'd1;
    return (n == '0) ? 32'd1 : n;
  endfunction

endpackage

@@ src/gsa_front.sv @@
// Front end: takes input transactions, decodes the command and queues them.
// Depends on gsa_pkg.
`timescale 1ns / 1ps

module gsa_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        hold_i,
  input  logic [gsa_pkg::CMD_W-1:0]   cmd_i,
  input  logic                        want_transient_i,
  input  logic                        resource_alive_i,
  input  logic                        descriptor_ok_i,
  input  logic [gsa_pkg::OWNER_W-1:0] owner_resource_i,
  input  logic [gsa_pkg::SLOT_W-1:0]  handle_slot_i,
  input  logic [gsa_pkg::GEN_W-1:0]   handle_gen_i,
  output logic                        cq_valid_o,
  input  logic                        cq_ready_i,
  output gsa_pkg::cmd_t               cq_data_o
);

  gsa_pkg::cmd_t fifo_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  gsa_pkg::op_e  op;
  logic          wr, rd;

  always_comb begin
    unique case (cmd_i)
      gsa_pkg::CMD_CREATE:  op = gsa_pkg::OP_CREATE;
      gsa_pkg::CMD_DESTROY: op = gsa_pkg::OP_DESTROY;
      gsa_pkg::CMD_QUERY:   op = gsa_pkg::OP_QUERY;
      gsa_pkg::CMD_RESET:   op = gsa_pkg::OP_RESET;
      gsa_pkg::CMD_RETIRE:  op = gsa_pkg::OP_RETIRE;
      gsa_pkg::CMD_FLUSH:   op = gsa_pkg::OP_FLUSH;
      default:              op = gsa_pkg::OP_NOP;
    endcase
  end

  assign full_o     = (cnt_q == 2'd2) || hold_i;
  assign wr         = push_i && !full_o;
  assign cq_valid_o = (cnt_q != 2'd0);
  assign rd         = cq_valid_o && cq_ready_i;
  assign cq_data_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      fifo_q[wp_q] <= '{op: op, want_t: want_transient_i, alive: resource_alive_i,
                        desc_ok: descriptor_ok_i, owner: owner_resource_i,
                        hslot: handle_slot_i, hgen: handle_gen_i};
    end
  end

endmodule

@@ src/gsa_back.sv @@
// Back end: slot table, free stack, ring cursor, dirty range and the sweeps.
// Holds the configuration registers. Depends on gsa_pkg.
`timescale 1ns / 1ps

module gsa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [gsa_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [gsa_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       cq_valid_i,
  output logic                       cq_ready_o,
  input  gsa_pkg::cmd_t              cq_data_i,
  output logic                       clearing_o,
  output logic                       res_push_o,
  input  logic                       res_full_i,
  output gsa_pkg::res_t              res_data_o
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_POP    = 6'b000100,
    S_SLOT   = 6'b001000,
    S_SWP_RD = 6'b010000,
    S_SWP_WR = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    SW_RESET  = 2'd0,
    SW_RETIRE = 2'd1,
    SW_REINIT = 2'd2
  } sweep_e;

  localparam int unsigned SW = gsa_pkg::SLOT_W;
  localparam int unsigned AW = gsa_pkg::STACK_AW;

  function automatic logic [2*SW-1:0] mark_dirty(input logic [SW-1:0] f,
                                                 input logic [SW-1:0] e,
                                                 input logic [SW-1:0] i);
    logic [SW-1:0] nf, ne, i1;
    i1 = i + 11'd1;
    nf = f;
    ne = e;
    if (e <= f) begin
      nf = i;
      ne = i1;
    end else begin
      if (i < f) nf = i;
      if (i1 > e) ne = i1;
    end
    return {nf, ne};
  endfunction

  state_e        state_q, state_d;
  sweep_e        swkind_q, swkind_d;
  logic [SW-1:0] pcap_q, pcap_d;
  logic [gsa_pkg::TCAP_W-1:0] tcap_q, tcap_d, cursor_q, cursor_d;
  logic          poison_q, poison_d, heap_q, heap_d;
  logic [SW-1:0] count_q, count_d, mark_q, mark_d;
  logic [SW-1:0] dfirst_q, dfirst_d, dend_q, dend_d;
  logic [SW-1:0] idx_q, idx_d, swp_q, swp_d, swlim_q, swlim_d;
  logic          orig_q, orig_d;
  logic [AW-1:0] origv_q, origv_d;
  gsa_pkg::cmd_t cur_q, cur_d;

  gsa_pkg::slot_t slot_mem [gsa_pkg::TOTAL_SLOTS];
  gsa_pkg::slot_t sm_rd_q, sm_wd;
  logic           sm_we, sm_re;
  logic [SW-1:0]  sm_wa, sm_ra;

  logic [AW-1:0] stack_mem [gsa_pkg::PERSISTENT_SLOTS];
  logic [AW-1:0] fs_rd_q, fs_wd, fs_wa, fs_ra;
  logic          fs_we, fs_re;

  logic [SW-1:0] total, trans_idx, cnt_m1, orig_val, pop_idx, sw_addr, swp_next;
  logic [SW-1:0] pcap_v;
  logic [gsa_pkg::TCAP_W-1:0] tcap_v;
  logic [gsa_pkg::GEN_W-1:0]  ng;
  logic          hdl_ok, hit;

  assign total     = pcap_q + {2'b00, tcap_q};
  assign trans_idx = pcap_q + {2'b00, cursor_q};
  assign cnt_m1    = count_q - 11'd1;
  assign orig_val  = pcap_q - count_q;
  assign pop_idx   = orig_q ? {1'b0, origv_q} : {1'b0, fs_rd_q};
  assign sw_addr   = (swkind_q == SW_RESET) ? pcap_q + swp_q : swp_q;
  assign swp_next  = swp_q + 11'd1;
  assign ng        = gsa_pkg::next_gen(sm_rd_q.gen);
  assign hdl_ok    = sm_rd_q.live && (sm_rd_q.gen == cur_q.hgen);
  assign hit       = sm_rd_q.live && ((swkind_q != SW_RETIRE) || (sm_rd_q.owner == cur_q.owner));

  always_comb begin
    pcap_v = cfg_data_i[SW-1:0];
    if (pcap_v < 11'(gsa_pkg::RESERVED_SLOTS)) pcap_v = 11'(gsa_pkg::RESERVED_SLOTS);
    if (pcap_v > 11'(gsa_pkg::PERSISTENT_SLOTS)) pcap_v = 11'(gsa_pkg::PERSISTENT_SLOTS);
    tcap_v = cfg_data_i[gsa_pkg::TCAP_W-1:0];
    if (tcap_v > 9'(gsa_pkg::TRANSIENT_SLOTS)) tcap_v = 9'(gsa_pkg::TRANSIENT_SLOTS);
  end

  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    state_d  = state_q;
    swkind_d = swkind_q;
    pcap_d   = pcap_q;
    tcap_d   = tcap_q;
    poison_d = poison_q;
    heap_d   = heap_q;
    count_d  = count_q;
    mark_d   = mark_q;
    cursor_d = cursor_q;
    dfirst_d = dfirst_q;
    dend_d   = dend_q;
    idx_d    = idx_q;
    swp_d    = swp_q;
    swlim_d  = swlim_q;
    orig_d   = orig_q;
    origv_d  = origv_q;
    cur_d    = cur_q;
    sm_we    = 1'b0;
    sm_wa    = idx_q;
    sm_wd    = '0;
    sm_re    = 1'b0;
    sm_ra    = idx_q;
    fs_we    = 1'b0;
    fs_wa    = count_q[AW-1:0];
    fs_wd    = idx_q[AW-1:0];
    fs_re    = 1'b0;
    fs_ra    = cnt_m1[AW-1:0];
    res_push_o  = 1'b0;
    res_data_o  = '0;
    cq_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        sm_we = 1'b1;
        sm_wa = swp_q;
        if (swp_q == 11'(gsa_pkg::TOTAL_SLOTS - 1)) begin
          swp_d   = '0;
          state_d = S_IDLE;
        end else begin
          swp_d = swp_next;
        end
      end

      S_IDLE: begin
        cfg_ready_o = 1'b1;
        if (cfg_valid_i) begin
          case (cfg_addr_i)
            gsa_pkg::CFG_PCAP, gsa_pkg::CFG_TCAP: begin
              if (cfg_addr_i == gsa_pkg::CFG_PCAP) pcap_d = pcap_v;
              else tcap_d = tcap_v;
              swp_d    = '0;
              swkind_d = SW_REINIT;
              swlim_d  = 11'(gsa_pkg::TOTAL_SLOTS);
              state_d  = S_SWP_RD;
            end
            gsa_pkg::CFG_POISON: poison_d = cfg_data_i[0];
            gsa_pkg::CFG_HEAP:   heap_d   = cfg_data_i[0];
            default: ;
          endcase
        end else if (cq_valid_i && !res_full_i) begin
          cq_ready_o = 1'b1;
          cur_d      = cq_data_i;
          unique case (cq_data_i.op)
            gsa_pkg::OP_CREATE: begin
              res_push_o = 1'b1;
              if (!heap_q) res_data_o.status = gsa_pkg::STS_DISABLED;
              else if (!cq_data_i.alive) res_data_o.status = gsa_pkg::STS_DEAD;
              else if (!cq_data_i.want_t) begin
                if (count_q == '0) res_data_o.status = gsa_pkg::STS_PERS_FULL;
                else if (!cq_data_i.desc_ok) res_data_o.status = gsa_pkg::STS_DESC_FAIL;
                else begin
                  res_push_o = 1'b0;
                  fs_re   = 1'b1;
                  orig_d  = (cnt_m1 < mark_q);
                  origv_d = orig_val[AW-1:0];
                  if (cnt_m1 < mark_q) mark_d = cnt_m1;
                  count_d = cnt_m1;
                  state_d = S_POP;
                end
              end else begin
                if (cursor_q >= tcap_q) res_data_o.status = gsa_pkg::STS_TRAN_FULL;
                else if (!cq_data_i.desc_ok) res_data_o.status = gsa_pkg::STS_DESC_FAIL;
                else begin
                  res_push_o = 1'b0;
                  idx_d    = trans_idx;
                  sm_re    = 1'b1;
                  sm_ra    = trans_idx;
                  cursor_d = cursor_q + 9'd1;
                  state_d  = S_SLOT;
                end
              end
            end
            gsa_pkg::OP_DESTROY, gsa_pkg::OP_QUERY: begin
              if ((cq_data_i.hgen == '0) || (cq_data_i.hslot >= total)) begin
                res_push_o        = 1'b1;
                res_data_o.status = gsa_pkg::STS_STALE;
              end else begin
                idx_d   = cq_data_i.hslot;
                sm_re   = 1'b1;
                sm_ra   = cq_data_i.hslot;
                state_d = S_SLOT;
              end
            end
            gsa_pkg::OP_RESET: begin
              if (cursor_q == '0) begin
                res_push_o = 1'b1;
              end else begin
                swp_d    = '0;
                swkind_d = SW_RESET;
                swlim_d  = {2'b00, cursor_q};
                state_d  = S_SWP_RD;
              end
            end
            gsa_pkg::OP_RETIRE: begin
              swp_d    = '0;
              swkind_d = SW_RETIRE;
              swlim_d  = total;
              state_d  = S_SWP_RD;
            end
            gsa_pkg::OP_FLUSH: begin
              res_push_o = 1'b1;
              if (!heap_q) res_data_o.status = gsa_pkg::STS_DISABLED;
              else if (dend_q > dfirst_q) begin
                res_data_o.fv = 1'b1;
                res_data_o.ff = dfirst_q;
                res_data_o.fe = dend_q;
                dfirst_d = '0;
                dend_d   = '0;
              end
            end
            default: res_push_o = 1'b1;
          endcase
        end
      end

      S_POP: begin
        idx_d   = pop_idx;
        sm_re   = 1'b1;
        sm_ra   = pop_idx;
        state_d = S_SLOT;
      end

      S_SLOT: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
        case (cur_q.op)
          gsa_pkg::OP_CREATE: begin
            sm_we = 1'b1;
            sm_wd = '{owner: cur_q.owner, gen: ng, live: 1'b1, trans: cur_q.want_t};
            {dfirst_d, dend_d} = mark_dirty(dfirst_q, dend_q, idx_q);
            res_data_o.slot = idx_q;
            res_data_o.gen  = ng;
          end
          gsa_pkg::OP_DESTROY: begin
            if (!hdl_ok) res_data_o.status = gsa_pkg::STS_STALE;
            else if (sm_rd_q.trans) res_data_o.status = gsa_pkg::STS_TRAN_REJ;
            else begin
              sm_we = 1'b1;
              sm_wd = '{owner: sm_rd_q.owner, gen: ng, live: 1'b0, trans: sm_rd_q.trans};
              if (poison_q) {dfirst_d, dend_d} = mark_dirty(dfirst_q, dend_q, idx_q);
              if (count_q < 11'(gsa_pkg::PERSISTENT_SLOTS)) begin
                fs_we   = 1'b1;
                count_d = count_q + 11'd1;
              end
              res_data_o.slot = idx_q;
            end
          end
          gsa_pkg::OP_QUERY: begin
            if (!hdl_ok) res_data_o.status = gsa_pkg::STS_STALE;
            else begin
              res_data_o.slot  = idx_q;
              res_data_o.gen   = cur_q.hgen;
              res_data_o.trans = sm_rd_q.trans;
            end
          end
          default: ;
        endcase
      end

      S_SWP_RD: begin
        sm_re   = 1'b1;
        sm_ra   = sw_addr;
        state_d = S_SWP_WR;
      end

      S_SWP_WR: begin
        sm_wa = sw_addr;
        fs_wd = sw_addr[AW-1:0];
        if (hit) begin
          sm_we = 1'b1;
          sm_wd = '{owner: sm_rd_q.owner, gen: ng, live: 1'b0, trans: sm_rd_q.trans};
          if (poison_q) {dfirst_d, dend_d} = mark_dirty(dfirst_q, dend_q, sw_addr);
          if ((swkind_q == SW_RETIRE) && !sm_rd_q.trans &&
              (count_q < 11'(gsa_pkg::PERSISTENT_SLOTS))) begin
            fs_we   = 1'b1;
            count_d = count_q + 11'd1;
          end
        end
        if (swp_next == swlim_q) begin
          state_d = S_IDLE;
          case (swkind_q)
            SW_RESET: begin
              cursor_d   = '0;
              res_push_o = 1'b1;
            end
            SW_RETIRE: res_push_o = 1'b1;
            default: begin
              // rebuild the pool: whole stack reads as its initial contents
              count_d  = pcap_q - 11'(gsa_pkg::RESERVED_SLOTS);
              mark_d   = pcap_q - 11'(gsa_pkg::RESERVED_SLOTS);
              cursor_d = '0;
              dfirst_d = '0;
              dend_d   = 11'(gsa_pkg::RESERVED_SLOTS);
            end
          endcase
        end else begin
          swp_d   = swp_next;
          state_d = S_SWP_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      swkind_q <= SW_RESET;
      pcap_q   <= 11'(gsa_pkg::PERSISTENT_SLOTS);
      tcap_q   <= 9'(gsa_pkg::TRANSIENT_SLOTS);
      poison_q <= 1'b0;
      heap_q   <= 1'b0;
      count_q  <= 11'(gsa_pkg::PERSISTENT_SLOTS - gsa_pkg::RESERVED_SLOTS);
      mark_q   <= 11'(gsa_pkg::PERSISTENT_SLOTS - gsa_pkg::RESERVED_SLOTS);
      cursor_q <= '0;
      dfirst_q <= '0;
      dend_q   <= 11'(gsa_pkg::RESERVED_SLOTS);
      swp_q    <= '0;
      swlim_q  <= '0;
    end else begin
      state_q  <= state_d;
      swkind_q <= swkind_d;
      pcap_q   <= pcap_d;
      tcap_q   <= tcap_d;
      poison_q <= poison_d;
      heap_q   <= heap_d;
      count_q  <= count_d;
      mark_q   <= mark_d;
      cursor_q <= cursor_d;
      dfirst_q <= dfirst_d;
      dend_q   <= dend_d;
      swp_q    <= swp_d;
      swlim_q  <= swlim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    orig_q  <= orig_d;
    origv_q <= origv_d;
    cur_q   <= cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) slot_mem[sm_wa] <= sm_wd;
    if (sm_re) sm_rd_q <= slot_mem[sm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) stack_mem[fs_wa] <= fs_wd;
    if (fs_re) fs_rd_q <= stack_mem[fs_ra];
  end

endmodule

@@ src/gsa_outq.sv @@
// Result queue: two entries between the back end and the result ports.
// Depends on gsa_pkg.
`timescale 1ns / 1ps

module gsa_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gsa_pkg::res_t data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output gsa_pkg::res_t head_o
);

  gsa_pkg::res_t fifo_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign head_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) fifo_q[wp_q] <= data_i;
  end

endmodule

@@ src/generational_slot_allocator.sv @@
// Generational slot allocator: front queue, back end executor, result queue.
// Create/destroy/query: after the front queue, a command that passes the early checks has the
// back end pop the free stack (persistent create only), read the slot and push the result;
// the front queue overlaps. Reset transients sweeps each ring slot in use, retire each slot
// of capacity, a read and a write step per slot on the single slot RAM port pair; a capacity
// write sweeps all slots to rebuild the pool. After reset a slot RAM clearing pass holds full_o high.
`timescale 1ns / 1ps

module generational_slot_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [gsa_pkg::CMD_W-1:0]   cmd_i,
  input  logic                        want_transient_i,
  input  logic                        resource_alive_i,
  input  logic                        descriptor_ok_i,
  input  logic [gsa_pkg::OWNER_W-1:0] owner_resource_i,
  input  logic [gsa_pkg::SLOT_W-1:0]  handle_slot_i,
  input  logic [gsa_pkg::GEN_W-1:0]   handle_gen_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [2:0]                  status_o,
  output logic [gsa_pkg::SLOT_W-1:0]  out_slot_o,
  output logic [gsa_pkg::GEN_W-1:0]   out_gen_o,
  output logic                        out_transient_o,
  output logic                        flush_valid_o,
  output logic [gsa_pkg::SLOT_W-1:0]  flush_first_o,
  output logic [gsa_pkg::SLOT_W-1:0]  flush_end_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gsa_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [gsa_pkg::CFG_DW-1:0]  cfg_data_i
);

  gsa_pkg::cmd_t cq_data;
  gsa_pkg::res_t res_data, head;
  logic          cq_valid, cq_ready, clearing, res_push, res_full;

  gsa_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o,
    .hold_i           (clearing),
    .cmd_i, .want_transient_i, .resource_alive_i, .descriptor_ok_i,
    .owner_resource_i, .handle_slot_i, .handle_gen_i,
    .cq_valid_o       (cq_valid),
    .cq_ready_i       (cq_ready),
    .cq_data_o        (cq_data)
  );

  gsa_back u_back (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i,
    .cq_valid_i (cq_valid),
    .cq_ready_o (cq_ready),
    .cq_data_i  (cq_data),
    .clearing_o (clearing),
    .res_push_o (res_push),
    .res_full_i (res_full),
    .res_data_o (res_data)
  );

  gsa_outq u_outq (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .empty_o,
    .pop_i,
    .head_o  (head)
  );

  assign status_o        = head.status;
  assign out_slot_o      = head.slot;
  assign out_gen_o       = head.gen;
  assign out_transient_o = head.trans;
  assign flush_valid_o   = head.fv;
  assign flush_first_o   = head.ff;
  assign flush_end_o     = head.fe;

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_cmd_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cq_valid && cq_ready) |-> (cfg_ready_o && !clearing))
    else $error("command taken while back end busy");

  a_result_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !empty_o) else $error("pushed result not visible");

endmodule

@@ sim/gsa_checker.sv @@
// Scoreboard for the generational slot allocator: mirrors the slot pool, predicts each result.
// Depends on gsa_pkg; watches the command, result and register write channels of the block.
`timescale 1ns / 1ps

module gsa_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic [gsa_pkg::CMD_W-1:0]   cmd_i,
  input  logic                        want_transient_i,
  input  logic                        resource_alive_i,
  input  logic                        descriptor_ok_i,
  input  logic [gsa_pkg::OWNER_W-1:0] owner_resource_i,
  input  logic [gsa_pkg::SLOT_W-1:0]  handle_slot_i,
  input  logic [gsa_pkg::GEN_W-1:0]   handle_gen_i,
  input  logic                        empty_i,
  input  logic                        pop_i,
  input  logic [2:0]                  status_i,
  input  logic [gsa_pkg::SLOT_W-1:0]  out_slot_i,
  input  logic [gsa_pkg::GEN_W-1:0]   out_gen_i,
  input  logic                        out_transient_i,
  input  logic                        flush_valid_i,
  input  logic [gsa_pkg::SLOT_W-1:0]  flush_first_i,
  input  logic [gsa_pkg::SLOT_W-1:0]  flush_end_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [gsa_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [gsa_pkg::CFG_DW-1:0]  cfg_data_i,
  output int                          pending_o,
  output int                          errors_o
);
  import gsa_pkg::*;

  logic [GEN_W-1:0]   gen_tab   [TOTAL_SLOTS];
  logic               live_tab  [TOTAL_SLOTS];
  logic               tr_tab    [TOTAL_SLOTS];
  logic [OWNER_W-1:0] owner_tab [TOTAL_SLOTS];
  int unsigned        free_stk  [PERSISTENT_SLOTS];
  int unsigned        free_cnt, ring_pos, dirty_lo, dirty_hi;
  int unsigned        pcap, tcap;
  logic               poison, heap_on;
  res_t               exp_q[$];

  assign pending_o = exp_q.size();

  function automatic void queue_expected(input res_t r);
    exp_q.insert(exp_q.size(), r);
  endfunction

  function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 32'd1;
    return (n == '0) ? 32'd1 : n;
  endfunction

  function automatic void widen_dirty(input int unsigned i);
    if (dirty_hi <= dirty_lo) begin
      dirty_lo = i;
      dirty_hi = i + 1;
    end else begin
      if (i < dirty_lo) dirty_lo = i;
      if (i + 1 > dirty_hi) dirty_hi = i + 1;
    end
  endfunction

  function automatic void free_push(input int unsigned i);
    if (free_cnt < PERSISTENT_SLOTS) begin
      free_stk[free_cnt] = i;
      free_cnt++;
    end
  endfunction

  function automatic void drop_slot(input int unsigned i);
    if (i >= TOTAL_SLOTS || !live_tab[i]) return;
    gen_tab[i]  = bump_gen(gen_tab[i]);
    live_tab[i] = 1'b0;
    if (poison) widen_dirty(i);
  endfunction

  function automatic void rebuild_pool();
    free_cnt = 0;
    for (int unsigned i = pcap; i > RESERVED_SLOTS; i--) free_push(i - 1);
    ring_pos = 0;
    dirty_lo = 0;
    dirty_hi = RESERVED_SLOTS;
  endfunction

  function automatic void reset_pool();
    pcap    = PERSISTENT_SLOTS;
    tcap    = TRANSIENT_SLOTS;
    poison  = 1'b0;
    heap_on = 1'b0;
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      gen_tab[i]   = '0;
      live_tab[i]  = 1'b0;
      tr_tab[i]    = 1'b0;
      owner_tab[i] = '0;
    end
    rebuild_pool();
  endfunction

  function automatic void write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
    int unsigned v;
    case (a)
      CFG_PCAP, CFG_TCAP: begin
        if (a == CFG_PCAP) begin
          v = 32'(d[PCAP_W-1:0]);
          if (v < RESERVED_SLOTS) v = RESERVED_SLOTS;
          if (v > PERSISTENT_SLOTS) v = PERSISTENT_SLOTS;
          pcap = v;
        end else begin
          v = 32'(d[TCAP_W-1:0]);
          if (v > TRANSIENT_SLOTS) v = TRANSIENT_SLOTS;
          tcap = v;
        end
        for (int i = 0; i < TOTAL_SLOTS; i++) drop_slot(i);
        rebuild_pool();
      end
      CFG_POISON: poison = d[0];
      CFG_HEAP:   heap_on = d[0];
      default: ;
    endcase
  endfunction

  function automatic bit handle_live(input int unsigned s, input logic [GEN_W-1:0] g);
    if (g == 0 || s >= pcap + tcap || s >= TOTAL_SLOTS) return 0;
    return live_tab[s] && gen_tab[s] == g;
  endfunction

  function automatic res_t predict_result(input logic [2:0] c, input logic wt, input logic al,
                                          input logic dok, input logic [OWNER_W-1:0] own,
                                          input int unsigned hs, input logic [GEN_W-1:0] hg);
    res_t r;
    int unsigned idx, total;
    bit got;
    r = '0;
    r.status = STS_OK;
    total = pcap + tcap;
    case (c)
      CMD_CREATE: begin
        if (!heap_on) r.status = STS_DISABLED;
        else if (!al) r.status = STS_DEAD;
        else begin
          got = 0;
          idx = 0;
          if (!wt) begin
            if (free_cnt == 0) r.status = STS_PERS_FULL;
            else begin
              free_cnt--;
              idx = free_stk[free_cnt];
              got = 1;
            end
          end else begin
            if (ring_pos >= tcap) r.status = STS_TRAN_FULL;
            else begin
              idx = pcap + ring_pos;
              ring_pos++;
              got = 1;
            end
          end
          if (got && !dok) begin
            // rewind the allocation
            r.status = STS_DESC_FAIL;
            if (!wt) free_push(idx);
            else ring_pos--;
          end else if (got) begin
            gen_tab[idx]   = bump_gen(gen_tab[idx]);
            live_tab[idx]  = 1'b1;
            tr_tab[idx]    = wt;
            owner_tab[idx] = own;
            widen_dirty(idx);
            r.slot = SLOT_W'(idx);
            r.gen  = gen_tab[idx];
          end
        end
      end
      CMD_DESTROY: begin
        if (!handle_live(hs, hg)) r.status = STS_STALE;
        else if (tr_tab[hs]) r.status = STS_TRAN_REJ;
        else begin
          drop_slot(hs);
          free_push(hs);
          r.slot = SLOT_W'(hs);
        end
      end
      CMD_QUERY: begin
        if (!handle_live(hs, hg)) r.status = STS_STALE;
        else begin
          r.slot  = SLOT_W'(hs);
          r.gen   = hg;
          r.trans = tr_tab[hs];
        end
      end
      CMD_RESET: begin
        for (int unsigned i = 0; i < ring_pos; i++)
          if (pcap + i < TOTAL_SLOTS) drop_slot(pcap + i);
        ring_pos = 0;
      end
      CMD_RETIRE: begin
        for (int unsigned i = 0; i < total && i < TOTAL_SLOTS; i++) begin
          if (live_tab[i] && owner_tab[i] == own) begin
            got = !tr_tab[i];
            drop_slot(i);
            if (got) free_push(i);
          end
        end
      end
      CMD_FLUSH: begin
        if (!heap_on) r.status = STS_DISABLED;
        else if (dirty_hi > dirty_lo) begin
          r.fv = 1'b1;
          r.ff = SLOT_W'(dirty_lo);
          r.fe = SLOT_W'(dirty_hi);
          dirty_lo = 0;
          dirty_hi = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      reset_pool();
      exp_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_addr_i, cfg_data_i);
      if (push_i && !full_i)
        queue_expected(predict_result(cmd_i, want_transient_i, resource_alive_i,
                                      descriptor_ok_i, owner_resource_i, 32'(handle_slot_i),
                                      handle_gen_i));
      if (pop_i && !empty_i) begin
        if (exp_q.size() == 0) begin
          $error("unexpected result transaction, status %0d", status_i);
          errors_o <= errors_o + 1;
        end else begin
          want = exp_q.pop_front();
          if (status_i !== want.status || out_slot_i !== want.slot || out_gen_i !== want.gen ||
              out_transient_i !== want.trans || flush_valid_i !== want.fv ||
              flush_first_i !== want.ff || flush_end_i !== want.fe) begin
            errors_o <= errors_o + 1;
            if (status_i !== want.status)
              $error("status: expected %0d, got %0d", want.status, status_i);
            if (out_slot_i !== want.slot)
              $error("out_slot: expected %0d, got %0d", want.slot, out_slot_i);
            if (out_gen_i !== want.gen)
              $error("out_gen: expected %0h, got %0h", want.gen, out_gen_i);
            if (out_transient_i !== want.trans)
              $error("out_transient: expected %0d, got %0d", want.trans, out_transient_i);
            if (flush_valid_i !== want.fv)
              $error("flush_valid: expected %0d, got %0d", want.fv, flush_valid_i);
            if (flush_first_i !== want.ff)
              $error("flush_first: expected %0d, got %0d", want.ff, flush_first_i);
            if (flush_end_i !== want.fe)
              $error("flush_end: expected %0d, got %0d", want.fe, flush_end_i);
          end
        end
      end
    end
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the generational slot allocator: clock, reset, stimulus and verdict.
// Depends on gsa_pkg, generational_slot_allocator and gsa_checker.
`timescale 1ns / 1ps

module tb;
  import gsa_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                clk_i, rst_ni;
  logic                push_i, full_o, empty_o, pop_i;
  logic [CMD_W-1:0]    cmd_i;
  logic                want_transient_i, resource_alive_i, descriptor_ok_i;
  logic [OWNER_W-1:0]  owner_resource_i;
  logic [SLOT_W-1:0]   handle_slot_i, out_slot_o, flush_first_o, flush_end_o;
  logic [GEN_W-1:0]    handle_gen_i, out_gen_o;
  logic [2:0]          status_o;
  logic                out_transient_o, flush_valid_o;
  logic                cfg_valid_i, cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_addr_i;
  logic [CFG_DW-1:0]   cfg_data_i;
  int                  pending, errors;
  int                  burst_left, idle_cycles;
  logic [SLOT_W-1:0]   seen_slot[$];
  logic [GEN_W-1:0]    seen_gen[$];

  generational_slot_allocator u_top (.*);

  gsa_checker u_chk (
    .clk_i, .rst_ni, .push_i, .full_i(full_o), .cmd_i, .want_transient_i, .resource_alive_i,
    .descriptor_ok_i, .owner_resource_i, .handle_slot_i, .handle_gen_i, .empty_i(empty_o),
    .pop_i, .status_i(status_o), .out_slot_i(out_slot_o), .out_gen_i(out_gen_o),
    .out_transient_i(out_transient_o), .flush_valid_i(flush_valid_o),
    .flush_first_i(flush_first_o), .flush_end_i(flush_end_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_addr_i, .cfg_data_i, .pending_o(pending),
    .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver stalls on its own pattern: always ready, coin flip, or mostly stalled.
  initial begin
    int mode, span;
    pop_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: pop_i = 1'b1;
          1: pop_i = 1'($urandom_range(0, 1));
          default: pop_i = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Collect handles handed back so that destroy and query mostly target real slots.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o && status_o == STS_OK && out_gen_o != 0) begin
      seen_slot.insert(seen_slot.size(), out_slot_o);
      seen_gen.insert(seen_gen.size(), out_gen_o);
      if (seen_slot.size() > 64) begin
        void'(seen_slot.pop_front());
        void'(seen_gen.pop_front());
      end
    end
  end

  // Watchdog: count cycles in which no transaction completes.
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send(input logic [2:0] c, input logic wt, input logic al, input logic dok,
                      input logic [OWNER_W-1:0] own, input logic [SLOT_W-1:0] hs,
                      input logic [GEN_W-1:0] hg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    cmd_i = c;
    want_transient_i = wt;
    resource_alive_i = al;
    descriptor_ok_i = dok;
    owner_resource_i = own;
    handle_slot_i = hs;
    handle_gen_i = hg;
    push_i = 1'b1;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic drain();
    push_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] a, input int unsigned d);
    cfg_addr_i = a;
    cfg_data_i = CFG_DW'(d);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_handle(input logic [2:0] c);
    int k;
    logic [SLOT_W-1:0] hs;
    logic [GEN_W-1:0] hg;
    if (seen_slot.size() != 0 && $urandom_range(0, 4) != 0) begin
      k = int'($urandom_range(0, seen_slot.size() - 1));
      hs = seen_slot[k];
      hg = seen_gen[k];
      case ($urandom_range(0, 7))
        0: hg = hg + 32'd1;
        1: hg = '0;
        2: hs = hs ^ 11'd1;
        default: ;
      endcase
    end else begin
      hs = SLOT_W'($urandom_range(0, TOTAL_SLOTS - 1));
      hg = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4);
    end
    send(c, 1'($urandom), 1'($urandom), 1'($urandom), OWNER_W'($urandom), hs, hg);
  endtask

  task automatic random_item();
    int pick;
    logic [OWNER_W-1:0] own;
    pick = $urandom_range(0, 99);
    own = OWNER_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3));
    if (pick < 40)
      send(CMD_CREATE, $urandom_range(0, 2) == 0, $urandom_range(0, 9) != 0,
           $urandom_range(0, 9) != 0, own, SLOT_W'($urandom_range(0, TOTAL_SLOTS - 1)),
           $urandom);
    else if (pick < 60) send_handle(CMD_DESTROY);
    else if (pick < 78) send_handle(CMD_QUERY);
    else if (pick < 84)
      send(CMD_RESET, 1'($urandom), 1'($urandom), 1'($urandom), own, SLOT_W'($urandom),
           $urandom);
    else if (pick < 88)
      send(CMD_RETIRE, 1'($urandom), 1'($urandom), 1'($urandom), own, SLOT_W'($urandom),
           $urandom);
    else if (pick < 98)
      send(CMD_FLUSH, 1'($urandom), 1'($urandom), 1'($urandom), own, SLOT_W'($urandom),
           $urandom);
    else
      send(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 1'($urandom), 1'($urandom),
           1'($urandom), own, SLOT_W'($urandom), $urandom);
  endtask

  initial begin
    int unsigned pcaps[6];
    int unsigned tcaps[6];
    pcaps = '{1024, 2, 6, 2047, 40, 0};
    tcaps = '{256, 0, 3, 511, 17, 1};
    rst_ni = 1'b0;
    push_i = 1'b0;
    cmd_i = CMD_QUERY;
    want_transient_i = 1'b0;
    resource_alive_i = 1'b0;
    descriptor_ok_i = 1'b0;
    owner_resource_i = '0;
    handle_slot_i = '0;
    handle_gen_i = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = CFG_PCAP;
    cfg_data_i = '0;
    burst_left = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // heap disabled after reset
    send(CMD_CREATE, 1'b0, 1'b1, 1'b1, 16'd1, '0, '0);
    send(CMD_FLUSH, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send(CMD_QUERY, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send(CMD_DESTROY, 1'b1, 1'b1, 1'b1, 16'hFFFF, 11'd1279, 32'hFFFF_FFFF);
    send(CMD_SPARE_LO, 1'b1, 1'b1, 1'b1, 16'hFFFF, 11'h7FF, 32'hFFFF_FFFF);
    send(CMD_SPARE_HI, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send(CMD_RESET, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send(CMD_RETIRE, 1'b0, 1'b0, 1'b0, 16'hFFFF, '0, '0);
    drain();
    write_reg(CFG_HEAP, 1);
    send(CMD_FLUSH, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send(CMD_CREATE, 1'b0, 1'b1, 1'b1, 16'd2, '0, '0);
    send(CMD_CREATE, 1'b1, 1'b1, 1'b1, 16'd2, '0, '0);
    send(CMD_CREATE, 1'b0, 1'b0, 1'b1, 16'd2, '0, '0);
    send(CMD_CREATE, 1'b0, 1'b1, 1'b0, 16'd2, '0, '0);
    send(CMD_CREATE, 1'b1, 1'b1, 1'b0, 16'd2, '0, '0);
    drain();
    send_handle(CMD_QUERY);
    send(CMD_DESTROY, 1'b0, 1'b0, 1'b0, '0, seen_slot[0], seen_gen[0]);
    send(CMD_DESTROY, 1'b0, 1'b0, 1'b0, '0, seen_slot[1], seen_gen[1]);
    send(CMD_RETIRE, 1'b0, 1'b0, 1'b0, 16'd2, '0, '0);
    drain();
    // small pools (one persistent and one transient slot): exhaust both regions
    write_reg(CFG_PCAP, 3);
    write_reg(CFG_TCAP, 1);
    write_reg(CFG_POISON, 1);
    send(CMD_CREATE, 1'b0, 1'b1, 1'b1, 16'd5, '0, '0);
    send(CMD_CREATE, 1'b0, 1'b1, 1'b1, 16'd5, '0, '0);
    send(CMD_CREATE, 1'b1, 1'b1, 1'b1, 16'd5, '0, '0);
    send(CMD_CREATE, 1'b1, 1'b1, 1'b1, 16'd5, '0, '0);
    send(CMD_RESET, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send(CMD_FLUSH, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_PCAP, pcaps[ph]);
      write_reg(CFG_TCAP, tcaps[ph]);
      write_reg(CFG_POISON, ph % 2);
      write_reg(CFG_HEAP, ph != 5);
      seen_slot.delete();
      seen_gen.delete();
      repeat (170) random_item();
      drain();
    end
    write_reg(CFG_HEAP, 0);
    repeat (20) random_item();
    drain();

    repeat (100) @(negedge clk_i);
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/gsa_pkg.sv
src/gsa_front.sv
src/gsa_back.sv
src/gsa_outq.sv
src/generational_slot_allocator.sv
sim/gsa_checker.sv
sim/tb.sv
